// ===== rtl/even_count_segment_tree_core_assert.svh =====
// Assertion macros for the even-count segment tree core.
// Depends on nothing; included by the top level only.
`ifndef EVEN_COUNT_SEGMENT_TREE_CORE_ASSERT_SVH
`define EVEN_COUNT_SEGMENT_TREE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ECST_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ECST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ecst_pkg.sv =====
// Shared types and constants for the even-count segment tree core.
// No dependencies; used by the channel interfaces and all modules.
package ecst_pkg;

   localparam int unsigned CMD_W     = 2;
   localparam int unsigned POS_W     = 11;
   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned COUNT_W   = 11;
   localparam int unsigned SIZE_W    = 11;

   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam int unsigned DEF_MAX_POSITIONS = 1024;
   localparam logic [SIZE_W-1:0] SIZE_RESET  = SIZE_W'(1024);

   // Register indexes on the CSR port (word address = byte address / 4).
   localparam logic [CSR_ADDR_W-3:0] CSR_SIZE_IDX = '0;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET   = 2'd0,
      CMD_EVENS = 2'd1,
      CMD_ODDS  = 2'd2
   } cmd_type;

endpackage

// ===== rtl/ecst_if.sv =====
// Request and response channel interfaces (valid/ready) of the tree core.
// Depends on ecst_pkg for field widths.
interface ecst_req_if import ecst_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           cmd;
   logic [POS_W-1:0]           left_pos;
   logic [POS_W-1:0]           right_pos;
   logic signed [VALUE_W-1:0]  new_value;

   modport source (output valid, cmd, left_pos, right_pos, new_value, input ready);
   modport sink   (input valid, cmd, left_pos, right_pos, new_value, output ready);
endinterface

interface ecst_rsp_if import ecst_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] count;
   logic               bad_range;

   modport source (output valid, count, bad_range, input ready);
   modport sink   (input valid, count, bad_range, output ready);
endinterface

// ===== rtl/ecst_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on ecst_pkg only by the house import convention.
module ecst_ram import ecst_pkg::*; #(
   parameter int unsigned WIDTH = 11,
   parameter int unsigned DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/even_count_segment_tree_core.sv =====
// Even-count segment tree core: counts even (or odd) values over ranges of a
// position array. Depends on ecst_pkg, ecst_if.sv, ecst_ram.sv and the
// assertion macro header.
//
// The tree is a heap-ordered binary tree kept in one synchronous RAM: node 1
// is the root, node k has children 2k and 2k+1, and position p (1-based)
// sits in leaf LEAVES+p-1, where LEAVES is MAX_POSITIONS rounded up to a
// power of two. Each node holds the number of even values below it.
// After reset a clearing pass writes zero into all 2*LEAVES nodes, one per
// cycle; no item is accepted meanwhile, while CSR writes are taken at any
// time. An item is handled one at a time: a set writes its leaf and then
// climbs to the root, reading the sibling and writing the parent at each
// level. A query walks the left and right range bounds upward together,
// with one RAM read per bound per level, before its result is loaded into
// the output register; the two bounds take turns on the one RAM read port.
// A rejected query goes straight to the output register, while a set
// outside the size in use and command 3 are dropped. The next item is
// accepted while a result still waits on the response channel. size_in_use
// (CSR word 0, reset 1024) only bounds which positions are accepted; a
// value above MAX_POSITIONS acts as MAX_POSITIONS.
module even_count_segment_tree_core import ecst_pkg::*; #(
   parameter int unsigned MAX_POSITIONS = DEF_MAX_POSITIONS
) (
   input  logic                  clock,
   input  logic                  reset,

   ecst_req_if.sink              req_if,
   ecst_rsp_if.source            rsp_if,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Tree geometry.
   localparam int unsigned LEAF_LOG  = $clog2(MAX_POSITIONS);
   localparam int unsigned LEAVES    = 1 << LEAF_LOG;
   localparam int unsigned DEPTH     = 2 * LEAVES;
   localparam int unsigned NODE_W    = LEAF_LOG + 1;   // node index
   localparam int unsigned BOUND_W   = NODE_W + 1;     // exclusive right bound
   localparam int unsigned CNT_W     = LEAF_LOG + 1;   // holds LEAVES
   localparam int unsigned SIZE_MAX  = (1 << SIZE_W) - 1;
   localparam int unsigned MAX_CLAMP = (MAX_POSITIONS > SIZE_MAX) ? SIZE_MAX
                                                                  : MAX_POSITIONS;

   typedef enum logic [6:0] {
      ST_CLEAR   = 7'b0000001,
      ST_IDLE    = 7'b0000010,
      ST_UPD_RD  = 7'b0000100,
      ST_UPD_WR  = 7'b0001000,
      ST_Q_LEFT  = 7'b0010000,
      ST_Q_RIGHT = 7'b0100000,
      ST_FIN     = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic [NODE_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [NODE_W-1:0]   upd_idx_ff, upd_idx_in;
   logic [CNT_W-1:0]    upd_cur_ff, upd_cur_in;
   logic [BOUND_W-1:0]  q_l_ff, q_l_in;
   logic [BOUND_W-1:0]  q_r_ff, q_r_in;
   logic [CNT_W-1:0]    acc_ff, acc_in;
   logic                pend_ff, pend_in;
   logic                odd_ff, odd_in;
   logic [CNT_W-1:0]    len_ff, len_in;
   logic                bad_ff, bad_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_bad_ff, rsp_bad_in;
   logic [SIZE_W-1:0]   size_ff, size_in;

   logic                mem_we;
   logic [NODE_W-1:0]   mem_waddr;
   logic [CNT_W-1:0]    mem_wdata;
   logic [NODE_W-1:0]   mem_raddr;
   logic [CNT_W-1:0]    mem_rdata;

   logic [SIZE_W-1:0]   eff_size;
   logic                req_fire;
   logic                set_ok;
   logic                query_bad;
   logic [CNT_W-1:0]    acc_sum;
   logic                rsp_load;
   logic                csr_write;

   ecst_ram #(
      .WIDTH (CNT_W),
      .DEPTH (DEPTH)
   ) u_tree_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // ---------------------------------------------------------------------
   // CSR port: single register, zero wait states.
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = CSR_DATA_W'(size_ff);

   always_comb begin
      size_in = size_ff;
      if (csr_write && (csr_paddr[CSR_ADDR_W-1:2] == CSR_SIZE_IDX)) begin
         size_in = csr_pwdata[SIZE_W-1:0];
      end
   end

   // Clamp the size in use to the tree capacity.
   assign eff_size = (size_ff > SIZE_W'(MAX_CLAMP)) ? SIZE_W'(MAX_CLAMP) : size_ff;

   // ---------------------------------------------------------------------
   // Item intake and decode.
   // ---------------------------------------------------------------------
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;

   assign set_ok    = (req_if.left_pos != '0) && (req_if.left_pos <= eff_size);
   assign query_bad = (req_if.left_pos == '0) ||
                      (req_if.left_pos > req_if.right_pos) ||
                      (req_if.right_pos > eff_size);

   // Add the node read in the previous cycle when it was marked for counting.
   assign acc_sum = acc_ff + (pend_ff ? mem_rdata : CNT_W'(0));

   // Output register is free when empty or being drained this cycle.
   assign rsp_load = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_if.ready);

   // ---------------------------------------------------------------------
   // Sequencer: clear pass, leaf-to-root update, bottom-up range count.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      upd_idx_in = upd_idx_ff;
      upd_cur_in = upd_cur_ff;
      q_l_in     = q_l_ff;
      q_r_in     = q_r_ff;
      acc_in     = acc_ff;
      pend_in    = pend_ff;
      odd_in     = odd_ff;
      len_in     = len_ff;
      bad_in     = bad_ff;
      mem_we     = 1'b0;
      mem_waddr  = upd_idx_ff;
      mem_wdata  = upd_cur_ff;
      mem_raddr  = upd_idx_ff ^ NODE_W'(1);

      unique case (state_ff)
         ST_CLEAR: begin
            // Zero one node per cycle; leave when the last one is written.
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + NODE_W'(1);
            if (&clr_cnt_ff) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               priority if (req_if.cmd == CMD_SET) begin
                  // Out-of-range set and unused command: drop silently.
                  if (set_ok) begin
                     upd_idx_in = NODE_W'(LEAVES) + NODE_W'(req_if.left_pos)
                                - NODE_W'(1);
                     upd_cur_in = CNT_W'(!req_if.new_value[0]);
                     state_in   = ST_UPD_RD;
                  end
               end else if (req_if.cmd == CMD_EVENS || req_if.cmd == CMD_ODDS) begin
                  odd_in  = (req_if.cmd == CMD_ODDS);
                  acc_in  = '0;
                  pend_in = 1'b0;
                  bad_in  = query_bad;
                  if (query_bad) begin
                     state_in = ST_FIN;
                  end else begin
                     q_l_in   = BOUND_W'(LEAVES) + BOUND_W'(req_if.left_pos)
                              - BOUND_W'(1);
                     q_r_in   = BOUND_W'(LEAVES) + BOUND_W'(req_if.right_pos);
                     len_in   = CNT_W'(req_if.right_pos - req_if.left_pos
                                       + POS_W'(1));
                     state_in = ST_Q_LEFT;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_UPD_RD: begin
            // Write the current node, fetch its sibling; the root ends the walk.
            mem_we = 1'b1;
            if (upd_idx_ff == NODE_W'(1)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_UPD_WR;
            end
         end

         ST_UPD_WR: begin
            // Parent count is this node plus its sibling.
            upd_cur_in = upd_cur_ff + mem_rdata;
            upd_idx_in = upd_idx_ff >> 1;
            state_in   = ST_UPD_RD;
         end

         ST_Q_LEFT: begin
            acc_in  = acc_sum;
            pend_in = 1'b0;
            if (q_l_ff >= q_r_ff) begin
               state_in = ST_FIN;
            end else begin
               // A right child on the left bound is fully inside: take it.
               mem_raddr = q_l_ff[NODE_W-1:0];
               pend_in   = q_l_ff[0];
               q_l_in    = q_l_ff + BOUND_W'(q_l_ff[0]);
               state_in  = ST_Q_RIGHT;
            end
         end

         ST_Q_RIGHT: begin
            // An odd exclusive right bound leaves its left neighbor inside.
            acc_in    = acc_sum;
            mem_raddr = NODE_W'(q_r_ff - BOUND_W'(1));
            pend_in   = q_r_ff[0];
            q_l_in    = q_l_ff >> 1;
            q_r_in    = q_r_ff >> 1;
            state_in  = ST_Q_LEFT;
         end

         ST_FIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Response register.
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_count_in = rsp_count_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_bad_in   = bad_ff;
         priority if (bad_ff) begin
            rsp_count_in = '0;
         end else if (odd_ff) begin
            rsp_count_in = COUNT_W'(len_ff - acc_ff);
         end else begin
            rsp_count_in = COUNT_W'(acc_ff);
         end
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.count     = rsp_count_ff;
   assign rsp_if.bad_range = rsp_bad_ff;

   // ---------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         size_ff      <= SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         size_ff      <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      upd_idx_ff   <= upd_idx_in;
      upd_cur_ff   <= upd_cur_in;
      q_l_ff       <= q_l_in;
      q_r_ff       <= q_r_in;
      acc_ff       <= acc_in;
      pend_ff      <= pend_in;
      odd_ff       <= odd_in;
      len_ff       <= len_in;
      bad_ff       <= bad_in;
      rsp_count_ff <= rsp_count_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
`include "even_count_segment_tree_core_assert.svh"

   `ECST_ASSERT_SAME(a_rejected_zero, clock, reset, rsp_valid_ff && rsp_bad_ff, rsp_count_ff == '0, "rejected query carries a nonzero count")
   `ECST_ASSERT_SAME(a_upd_idx_live, clock, reset, state_ff == ST_UPD_RD || state_ff == ST_UPD_WR, upd_idx_ff != '0, "update walk reached node zero")
   `ECST_ASSERT_SAME(a_bounds_order, clock, reset, state_ff == ST_Q_LEFT || state_ff == ST_Q_RIGHT, q_l_ff <= q_r_ff, "query bounds crossed")
   `ECST_ASSERT_NEXT(a_fin_drains, clock, reset, state_ff == ST_FIN && rsp_load, rsp_valid_ff && state_ff == ST_IDLE, "finished query not loaded into the output register")

endmodule
